FILE: src/mbpfc_pkg.sv
// Shared types, constants and CRC/request helpers for the Modbus poll frame checker.
// Depends on nothing; every module of the block imports it.
package mbpfc_pkg;

   // Frame store geometry
   localparam int MAX_FRAME   = 32;
   localparam int MIN_FRAME   = 5;
   localparam int IDX_W       = $clog2(MAX_FRAME);
   localparam int LEN_W       = $clog2(MAX_FRAME + 1);
   localparam int EMIT_W      = $clog2(MAX_FRAME + 3);
   localparam int CFG_LEN_W   = 6;
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // CRC-16, reflected
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Response frame checks
   localparam logic [7:0] FC_READ  = 8'h03;
   localparam logic [7:0] FC_WRITE = 8'h06;
   localparam logic [7:0] BC_MEAS  = 8'h04;
   localparam logic [7:0] BC_THR   = 8'h02;
   localparam logic [IDX_W-1:0] POS_FUNC  = IDX_W'(1);
   localparam logic [IDX_W-1:0] POS_COUNT = IDX_W'(2);

   // Host framing bytes
   localparam logic [7:0] HOST_HDR0    = 8'h55;
   localparam logic [7:0] HOST_HDR1    = 8'hAA;
   localparam logic [7:0] HOST_TRAILER = 8'hDD;

   // Request contents
   localparam logic [7:0] REG_MEAS  = 8'hA4;
   localparam logic [7:0] REG_THR   = 8'h9E;
   localparam logic [7:0] REG_TIME  = 8'h12;
   localparam logic [7:0] CNT_TWO   = 8'h02;
   localparam logic [7:0] CNT_ONE   = 8'h01;
   localparam int         REQ_LEN   = 8;
   localparam int         REQ_BODY  = 6;

   // Request / frame kinds
   localparam logic [1:0] KIND_MEAS = 2'd0;
   localparam logic [1:0] KIND_THR  = 2'd1;
   localparam logic [1:0] KIND_TIME = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [1:0] KIND_OUT  = 2'd2;

   // Result destinations
   localparam logic DEST_BUS  = 1'b0;
   localparam logic DEST_HOST = 1'b1;

   // Input item types
   localparam logic TYPE_RX   = 1'b0;
   localparam logic TYPE_SEND = 1'b1;

   // Register indexes (byte address bit 2)
   localparam logic REG_FRAME_LENGTH   = 1'b0;
   localparam logic REG_DEVICE_ADDRESS = 1'b1;

   localparam logic [CFG_LEN_W-1:0] FRAME_LENGTH_RST   = CFG_LEN_W'(9);
   localparam logic [7:0]           DEVICE_ADDRESS_RST = 8'h01;

   // Job handed from front to back
   typedef struct packed {
      logic             is_frame;
      logic [1:0]       kind;
      logic [7:0]       dev_addr;
      logic [LEN_W-1:0] len;
      logic [15:0]      crc;
   } job_type;

   // Frame store write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } store_wr_type;

   // One byte through the CRC, bit by bit
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_i, input logic [7:0] b);
      logic [15:0] c;
      c = crc_i ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // Body byte of a poll request (positions before the CRC)
   function automatic logic [7:0] req_byte(input logic [1:0] kind, input logic [7:0] dev,
                                           input logic [2:0] pos);
      logic [7:0] b;
      case (pos)
         3'd0: b = dev;
         3'd1: b = (kind == KIND_TIME) ? FC_WRITE : FC_READ;
         3'd3: begin
            case (kind)
               KIND_MEAS: b = REG_MEAS;
               KIND_THR:  b = REG_THR;
               default:   b = REG_TIME;
            endcase
         end
         3'd5: b = (kind == KIND_MEAS) ? CNT_TWO : CNT_ONE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

FILE: src/mbpfc_queue.sv
// Two-entry job queue between the receive front end and the output sequencer.
// Depends on mbpfc_pkg for the job type and depth.
module mbpfc_queue import mbpfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    avail,
   output job_type pop_job
);

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign avail   = (count_ff != '0);
   assign pop_job = entry_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entries need no reset
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: src/mbpfc_front.sv
// Receive front end: takes requests, writes bus bytes to the frame store, runs the CRC
// and queues send and frame-check jobs. Depends on mbpfc_pkg.
module mbpfc_front import mbpfc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [7:0] rx_byte, [9:8] request_kind, rest zero
   input  logic [0:0]           req_tuser,   // [0] req_type
   input  logic [CFG_LEN_W-1:0] frame_length,
   input  logic [7:0]           device_address,
   input  logic                 frame_done,
   input  logic                 q_full,
   output logic                 q_push,
   output job_type              q_job,
   output store_wr_type         store_wr
);

   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [15:0]      crc_ff, crc_in;
   logic             busy_ff, busy_in;

   logic             accept;
   logic [7:0]       rx;
   logic [1:0]       kind;
   logic [LEN_W-1:0] len;
   logic [LEN_W-1:0] idx_ext;
   logic [15:0]      crc_next;
   logic             complete;

   assign rx         = req_tdata[7:0];
   assign kind       = req_tdata[9:8];
   assign req_tready = !busy_ff && !q_full;
   assign accept     = req_tvalid && req_tready;
   assign idx_ext    = LEN_W'(byte_index_ff);

   // Clamp the configured length into the store's range
   always_comb begin
      if (frame_length < CFG_LEN_W'(MIN_FRAME)) begin
         len = LEN_W'(MIN_FRAME);
      end else if (frame_length > CFG_LEN_W'(MAX_FRAME)) begin
         len = LEN_W'(MAX_FRAME);
      end else begin
         len = LEN_W'(frame_length);
      end
   end

   // CRC covers all but the last two bytes
   assign crc_next = (idx_ext < len - LEN_W'(2)) ? crc_byte(crc_ff, rx) : crc_ff;
   assign complete = (idx_ext + LEN_W'(1)) >= len;

   // Request classification
   always_comb begin
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      busy_in       = busy_ff;
      q_push        = 1'b0;
      q_job         = '{is_frame: 1'b0, kind: kind, dev_addr: device_address,
                        len: len, crc: crc_next};
      store_wr      = '{en: 1'b0, addr: byte_index_ff, data: rx};
      if (frame_done) begin
         busy_in = 1'b0;
      end
      if (accept) begin
         if (req_tuser[0] == TYPE_SEND) begin
            q_push = (kind != KIND_NONE);
         end else begin
            store_wr.en = 1'b1;
            if (complete) begin
               q_push         = 1'b1;
               q_job.is_frame = 1'b1;
               busy_in        = 1'b1;
               byte_index_in  = '0;
               crc_in         = CRC_INIT;
            end else begin
               byte_index_in = byte_index_ff + 1'b1;
               crc_in        = crc_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_index_ff <= '0;
         crc_ff        <= CRC_INIT;
         busy_ff       <= 1'b0;
      end else begin
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

FILE: src/mbpfc_back.sv
// Output sequencer: owns the frame store, builds poll requests with CRC, checks a
// completed frame and forwards it to the host. Depends on mbpfc_pkg.
module mbpfc_back import mbpfc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  store_wr_type store_wr,
   input  logic         q_avail,
   input  job_type      q_job,
   output logic         q_pop,
   output logic         frame_done,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [7:0] out_byte
   output logic [2:0]   rsp_tuser,   // [0] out_dest, [2:1] frame_kind
   output logic         rsp_tlast    // last_byte
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SEND = 2'd1;
   localparam logic [1:0] ST_CHK  = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [7:0]        store_mem [MAX_FRAME];
   logic [7:0]        rd_data_ff;
   logic [IDX_W-1:0]  rd_addr;

   logic [1:0]        state_ff, state_in;
   job_type           job_ff, job_in;
   logic [2:0]        pos_ff, pos_in;
   logic [15:0]       crc_ff, crc_in;
   logic [2:0]        chk_ff, chk_in;
   logic [7:0]        crc_lo_ff, crc_lo_in;
   logic [7:0]        crc_hi_ff, crc_hi_in;
   logic [7:0]        func_ff, func_in;
   logic [1:0]        fkind_ff, fkind_in;
   logic [EMIT_W-1:0] emit_ff, emit_in;
   logic              fresh_ff, fresh_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_dest_ff, out_dest_in;
   logic [1:0]        out_kind_ff, out_kind_in;
   logic              out_last_ff, out_last_in;

   logic              load_ok;
   logic [7:0]        req_b;
   logic [EMIT_W-1:0] emit_end;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_kind_ff, out_dest_ff};
   assign rsp_tlast  = out_last_ff;

   assign load_ok  = !out_valid_ff || rsp_tready;
   assign req_b    = req_byte(job_ff.kind, job_ff.dev_addr, pos_ff);
   assign emit_end = EMIT_W'(job_ff.len) + EMIT_W'(2);

   // Store read address: check reads first, then the forwarded bytes
   always_comb begin
      if (state_ff == ST_CHK) begin
         case (chk_ff)
            3'd0:    rd_addr = IDX_W'(job_ff.len - LEN_W'(2));
            3'd1:    rd_addr = IDX_W'(job_ff.len - LEN_W'(1));
            3'd2:    rd_addr = POS_FUNC;
            default: rd_addr = POS_COUNT;
         endcase
      end else begin
         rd_addr = IDX_W'(emit_ff - EMIT_W'(2));
      end
   end

   // Frame store, registered read
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[store_wr.addr] <= store_wr.data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      chk_in       = chk_ff;
      crc_lo_in    = crc_lo_ff;
      crc_hi_in    = crc_hi_ff;
      func_in      = func_ff;
      fkind_in     = fkind_ff;
      emit_in      = emit_ff;
      fresh_in     = 1'b1;
      q_pop        = 1'b0;
      frame_done   = 1'b0;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_byte_in  = out_byte_ff;
      out_dest_in  = out_dest_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_avail) begin
               q_pop  = 1'b1;
               job_in = q_job;
               pos_in = '0;
               crc_in = CRC_INIT;
               chk_in = '0;
               state_in = q_job.is_frame ? ST_CHK : ST_SEND;
            end
         end

         // Poll request: six body bytes through the CRC, then CRC low, high
         ST_SEND: begin
            if (load_ok) begin
               out_valid_in = 1'b1;
               out_dest_in  = DEST_BUS;
               out_kind_in  = KIND_OUT;
               out_last_in  = (pos_ff == 3'(REQ_LEN - 1));
               if (pos_ff < 3'(REQ_BODY)) begin
                  out_byte_in = req_b;
                  crc_in      = crc_byte(crc_ff, req_b);
               end else if (pos_ff == 3'(REQ_BODY)) begin
                  out_byte_in = crc_ff[7:0];
               end else begin
                  out_byte_in = crc_ff[15:8];
               end
               pos_in = pos_ff + 1'b1;
               if (pos_ff == 3'(REQ_LEN - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end

         // Read CRC bytes, function code and byte count, then decide
         ST_CHK: begin
            chk_in = chk_ff + 1'b1;
            case (chk_ff)
               3'd1: crc_lo_in = rd_data_ff;
               3'd2: crc_hi_in = rd_data_ff;
               3'd3: func_in   = rd_data_ff;
               3'd4: begin
                  if ({crc_hi_ff, crc_lo_ff} == job_ff.crc && func_ff == FC_READ &&
                      (rd_data_ff inside {BC_MEAS, BC_THR})) begin
                     fkind_in = (rd_data_ff == BC_MEAS) ? KIND_MEAS : KIND_THR;
                     emit_in  = '0;
                     fresh_in = 1'b0;
                     state_in = ST_EMIT;
                  end else begin
                     frame_done = 1'b1;
                     state_in   = ST_IDLE;
                  end
               end
               default: ;
            endcase
         end

         // Header, stored bytes, trailer
         ST_EMIT: begin
            if (load_ok && (emit_ff < EMIT_W'(2) || emit_ff == emit_end || fresh_ff)) begin
               out_valid_in = 1'b1;
               out_dest_in  = DEST_HOST;
               out_kind_in  = fkind_ff;
               out_last_in  = (emit_ff == emit_end);
               if (emit_ff == '0) begin
                  out_byte_in = HOST_HDR0;
               end else if (emit_ff == EMIT_W'(1)) begin
                  out_byte_in = HOST_HDR1;
               end else if (emit_ff == emit_end) begin
                  out_byte_in = HOST_TRAILER;
               end else begin
                  out_byte_in = rd_data_ff;
               end
               emit_in  = emit_ff + 1'b1;
               fresh_in = 1'b0;
               if (emit_ff == emit_end) begin
                  frame_done = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         fresh_ff     <= fresh_in;
      end
   end

   // Payload and work registers
   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      pos_ff      <= pos_in;
      crc_ff      <= crc_in;
      chk_ff      <= chk_in;
      crc_lo_ff   <= crc_lo_in;
      crc_hi_ff   <= crc_hi_in;
      func_ff     <= func_in;
      fkind_ff    <= fkind_in;
      emit_ff     <= emit_in;
      out_byte_ff <= out_byte_in;
      out_dest_ff <= out_dest_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: src/modbus_poll_frame_checker_core.sv
// Top level of the Modbus RTU poll frame checker: register port, front end, job queue
// and output sequencer. Depends on mbpfc_pkg, mbpfc_front, mbpfc_queue, mbpfc_back.
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         tvalid/tready          bus byte or send request (tuser = type)
//   rsp_*     out        tvalid/tready, tlast   emitted byte, destination and kind
//   csr_*     in/out     APB psel/penable       frame_length @0x0, device_address @0x4
//
// A completed frame holds off requests while it is checked through store reads and, if
// valid, forwarded: header and trailer at one byte a cycle while the output takes them,
// stored bytes more slowly as each waits on the store's registered read. A poll request is
// 8 bytes at one a cycle while taken, its CRC computed a byte per cycle as it goes.
// Reset is synchronous; the frame store is not cleared. Either side may stall freely:
// the output register holds a byte until taken, the two-entry queue absorbs requests.
module modbus_poll_frame_checker_core import mbpfc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [9:8] request_kind, [15:10] zero
   input  logic [0:0]  req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]  rsp_tuser,   // [0] out_dest, [2:1] frame_kind
   output logic        rsp_tlast,   // last_byte
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [CFG_LEN_W-1:0] frame_length_ff, frame_length_in;
   logic [7:0]           device_address_ff, device_address_in;
   logic                 csr_write;

   logic         q_push, q_full, q_pop, q_avail;
   job_type      push_job, pop_job;
   store_wr_type store_wr;
   logic         frame_done;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frame_length_in   = frame_length_ff;
      device_address_in = device_address_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_FRAME_LENGTH:   frame_length_in   = csr_pwdata[CFG_LEN_W-1:0];
            REG_DEVICE_ADDRESS: device_address_in = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_FRAME_LENGTH:   csr_prdata = 32'(frame_length_ff);
         REG_DEVICE_ADDRESS: csr_prdata = 32'(device_address_ff);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff   <= FRAME_LENGTH_RST;
         device_address_ff <= DEVICE_ADDRESS_RST;
      end else begin
         frame_length_ff   <= frame_length_in;
         device_address_ff <= device_address_in;
      end
   end

   mbpfc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .frame_length   (frame_length_ff),
      .device_address (device_address_ff),
      .frame_done     (frame_done),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (push_job),
      .store_wr       (store_wr)
   );

   mbpfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .avail    (q_avail),
      .pop_job  (pop_job)
   );

   mbpfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .store_wr   (store_wr),
      .q_avail    (q_avail),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .frame_done (frame_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
